### src/tsbp_pkg.sv
// ----------------------------------------------------------------------------
// tsbp_pkg
// Shared types and constants for the tagged sensor byte parser.
// ----------------------------------------------------------------------------
package tsbp_pkg;

   typedef logic [7:0]         byte_type;
   typedef logic signed [15:0] heading_type;
   typedef logic signed [12:0] goal_type;

   // Working width of the heading arithmetic: covers 255*100+255 plus both offsets.
   localparam int CALC_W = 18;
   typedef logic signed [CALC_W-1:0] calc_type;

   localparam calc_type FULL_TURN   = 18'sd3600;
   localparam calc_type HEADING_MAX = 18'sd32767;
   localparam calc_type HEADING_MIN = -18'sd32768;
   localparam logic [6:0] COMPASS_SCALE = 7'd100;

   localparam byte_type TAG_X = 8'h58;
   localparam byte_type TAG_Y = 8'h59;
   localparam byte_type TAG_C = 8'h43;
   localparam byte_type TAG_O = 8'h4F;
   localparam byte_type TAG_L = 8'h4C;
   localparam byte_type TAG_B = 8'h42;
   localparam byte_type TAG_NONE = 8'h00;

   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_CAPTURE = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // Register index is paddr[2] (one 32-bit register per word).
   localparam logic REG_GOAL_OFFSET = 1'b0;

endpackage

### src/tsbp_if.sv
// ----------------------------------------------------------------------------
// tsbp request and response channels
// Valid/ready channel interfaces for the parser's input bytes and results.
// ----------------------------------------------------------------------------
interface tsbp_req_if
   import tsbp_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     mode;
   byte_type rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface tsbp_rsp_if
   import tsbp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   byte_type    ball_x;
   byte_type    ball_y;
   byte_type    accel_y;
   byte_type    ball_found;
   heading_type heading;
   logic        heading_updated;

   modport source (output valid, output ball_x, output ball_y, output accel_y,
                   output ball_found, output heading, output heading_updated,
                   input ready);
   modport sink   (input valid, input ball_x, input ball_y, input accel_y,
                   input ball_found, input heading, input heading_updated,
                   output ready);
endinterface

### src/tagged_sensor_byte_parser.sv
// ----------------------------------------------------------------------------
// tagged_sensor_byte_parser
// Parses tag/data serial byte pairs into ball, accelerometer and heading values.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per received byte (mode 0) or a capture
//   command (mode 1) that copies the current heading into the auto offset.
//   rsp_ch returns exactly one result per request: the four stored sensor
//   bytes, the heading and a flag telling whether this request computed a
//   new heading.
//   The configuration port holds goal_offset at byte address 0; write it
//   only while no request is outstanding.
// Timing:
//   A result appears in the cycle after its request is accepted. One request
//   is accepted every cycle while no result stalls; the single result register decides the rate.
//   The parser state doubles as the result payload, so a stalled result
//   holds and req_ch.ready stays high as long as the result is taken in the
//   same cycle.
// Reset:
//   Synchronous reset clears all stored bytes, the pending tag, heading,
//   auto offset and goal_offset, and empties the result register.
// ----------------------------------------------------------------------------
module tagged_sensor_byte_parser
   import tsbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tsbp_req_if.sink              req_ch,
   tsbp_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic        accept;
   logic        csr_write;

   goal_type    goal_offset_ff;
   byte_type    pending_tag_ff,    pending_tag_in;
   byte_type    compass_high_ff,   compass_high_in;
   byte_type    ball_x_ff,         ball_x_in;
   byte_type    ball_y_ff,         ball_y_in;
   byte_type    accel_y_ff,        accel_y_in;
   byte_type    ball_found_ff,     ball_found_in;
   heading_type heading_ff,        heading_in;
   heading_type auto_offset_ff,    auto_offset_in;
   logic        updated_ff,        updated_in;
   logic        rsp_valid_ff;
   heading_type new_heading;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_GOAL_OFFSET) ? CSR_DATA_W'(goal_offset_ff)
                                                   : '0;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   tsbp_heading u_heading (
      .compass_high (compass_high_ff),
      .compass_low  (req_ch.rx_byte),
      .goal_offset  (goal_offset_ff),
      .auto_offset  (auto_offset_ff),
      .heading      (new_heading)
   );

   always_comb begin
      pending_tag_in  = pending_tag_ff;
      compass_high_in = compass_high_ff;
      ball_x_in       = ball_x_ff;
      ball_y_in       = ball_y_ff;
      accel_y_in      = accel_y_ff;
      ball_found_in   = ball_found_ff;
      heading_in      = heading_ff;
      auto_offset_in  = auto_offset_ff;
      updated_in      = 1'b0;

      if (req_ch.mode == MODE_CAPTURE) begin
         auto_offset_in = heading_ff;
      end else begin
         // A data tag consumes the byte; anything else makes it the new pending tag.
         unique case (pending_tag_ff)
            TAG_X: begin
               ball_x_in      = req_ch.rx_byte;
               pending_tag_in = TAG_NONE;
            end
            TAG_Y: begin
               ball_y_in      = req_ch.rx_byte;
               pending_tag_in = TAG_NONE;
            end
            TAG_C: begin
               compass_high_in = req_ch.rx_byte;
               pending_tag_in  = TAG_NONE;
            end
            TAG_O: begin
               heading_in     = new_heading;
               updated_in     = 1'b1;
               pending_tag_in = TAG_NONE;
            end
            TAG_L: begin
               accel_y_in     = req_ch.rx_byte;
               pending_tag_in = TAG_NONE;
            end
            TAG_B: begin
               ball_found_in  = req_ch.rx_byte;
               pending_tag_in = TAG_NONE;
            end
            default: begin
               pending_tag_in = req_ch.rx_byte;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_offset_ff  <= '0;
         pending_tag_ff  <= TAG_NONE;
         compass_high_ff <= '0;
         ball_x_ff       <= '0;
         ball_y_ff       <= '0;
         accel_y_ff      <= '0;
         ball_found_ff   <= '0;
         heading_ff      <= '0;
         auto_offset_ff  <= '0;
         updated_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write && paddr[2] == REG_GOAL_OFFSET) begin
            goal_offset_ff <= pwdata[12:0];
         end
         if (accept) begin
            pending_tag_ff  <= pending_tag_in;
            compass_high_ff <= compass_high_in;
            ball_x_ff       <= ball_x_in;
            ball_y_ff       <= ball_y_in;
            accel_y_ff      <= accel_y_in;
            ball_found_ff   <= ball_found_in;
            heading_ff      <= heading_in;
            auto_offset_ff  <= auto_offset_in;
            updated_ff      <= updated_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ball_x          = ball_x_ff;
   assign rsp_ch.ball_y          = ball_y_ff;
   assign rsp_ch.accel_y         = accel_y_ff;
   assign rsp_ch.ball_found      = ball_found_ff;
   assign rsp_ch.heading         = heading_ff;
   assign rsp_ch.heading_updated = updated_ff;

endmodule

### src/tsbp_heading.sv
// ----------------------------------------------------------------------------
// tsbp_heading
// Forms the corrected compass heading from the two compass bytes and offsets.
// ----------------------------------------------------------------------------
module tsbp_heading
   import tsbp_pkg::*;
(
   input  byte_type    compass_high,
   input  byte_type    compass_low,
   input  goal_type    goal_offset,
   input  heading_type auto_offset,
   output heading_type heading
);

   logic [14:0] scaled;
   calc_type    raw;
   calc_type    wrap_low;
   calc_type    wrap_high;

   always_comb begin
      scaled = 15'(compass_high) * 15'(COMPASS_SCALE);
      raw    = $signed({3'b000, scaled}) + $signed({10'd0, compass_low})
               - CALC_W'(goal_offset) - CALC_W'(auto_offset);

      // Each correction is applied at most once, so a wide value may stay out of range.
      wrap_low  = (raw < 0) ? raw + FULL_TURN : raw;
      wrap_high = (wrap_low > FULL_TURN) ? wrap_low - FULL_TURN : wrap_low;

      if (wrap_high > HEADING_MAX) begin
         heading = 16'sh7FFF;
      end else if (wrap_high < HEADING_MIN) begin
         heading = 16'sh8000;
      end else begin
         heading = wrap_high[15:0];
      end
   end

endmodule

### src/tsbp_checker.sv
// ----------------------------------------------------------------------------
// tsbp_checker
// Port-level checks for the tagged sensor byte parser, bound to the top level.
// ----------------------------------------------------------------------------
module tsbp_checker
   import tsbp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input heading_type rsp_heading,
   input logic        rsp_heading_updated
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every accepted request shows a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no result");

   // The parser never blocks requests while its result register is empty.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request blocked with empty result register");

   // A capture request never reports a new heading and leaves the heading as it was.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_CAPTURE)
      |=> (!rsp_heading_updated && rsp_heading == $past(rsp_heading)))
      else $error("capture request changed the heading");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_heading)))
      else $error("stalled result changed");

endmodule

bind tagged_sensor_byte_parser tsbp_checker u_tsbp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_mode            (req_ch.mode),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_heading         (rsp_ch.heading),
   .rsp_heading_updated (rsp_ch.heading_updated)
);
